### hdl/pcd_pkg.sv
// Shared types, chunk tags and byte-packing helpers for the PNG chunk deframer.
`timescale 1ns / 1ps

package pcd_pkg;

	localparam int unsigned SIG_BYTES = 8;
	localparam int unsigned CNT_W     = 31;

	localparam logic [31:0] TAG_IHDR = 32'h4948_4452;
	localparam logic [31:0] TAG_PLTE = 32'h504C_5445;
	localparam logic [31:0] TAG_IDAT = 32'h4944_4154;
	localparam logic [31:0] TAG_IEND = 32'h4945_4E44;

	typedef enum logic [2:0] {
		KIND_OTHER = 3'd0,
		KIND_IHDR  = 3'd1,
		KIND_PLTE  = 3'd2,
		KIND_IDAT  = 3'd3,
		KIND_IEND  = 3'd4
	} chunk_kind_t;

	function automatic chunk_kind_t kind_of(input logic [31:0] tag);
		chunk_kind_t k;
		priority if (tag == TAG_IHDR) k = KIND_IHDR;
		else if (tag == TAG_PLTE) k = KIND_PLTE;
		else if (tag == TAG_IDAT) k = KIND_IDAT;
		else if (tag == TAG_IEND) k = KIND_IEND;
		else k = KIND_OTHER;
		return k;
	endfunction

	function automatic logic [31:0] put_be(input logic [31:0] word, input logic [1:0] pos,
			input logic [7:0] b);
		logic [31:0] w;
		w = word;
		unique case (pos)
			2'd0: w[31:24] = b;
			2'd1: w[23:16] = b;
			2'd2: w[15:8]  = b;
			2'd3: w[7:0]   = b;
			default: w = word;
		endcase
		return w;
	endfunction

endpackage

### hdl/pcd_channels.sv
// Valid/ready channel interfaces for raw file bytes and chunk reports.
`timescale 1ns / 1ps

interface pcd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] byte_in;

	modport source (output valid, output byte_in, input ready);
	modport sink (input valid, input byte_in, output ready);
endinterface

interface pcd_chunk_if
	import pcd_pkg::*;
	;
	logic        valid;
	logic        ready;
	logic [31:0] chunk_type_raw;
	chunk_kind_t chunk_kind;
	logic [31:0] chunk_length;
	logic [31:0] crc_value;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [7:0]  bit_depth;
	logic [7:0]  colour_type;
	logic [7:0]  compression_method;
	logic [7:0]  filter_method;
	logic [7:0]  interlace_method;

	modport source (output valid, output chunk_type_raw, output chunk_kind,
		output chunk_length, output crc_value, output image_width, output image_height,
		output bit_depth, output colour_type, output compression_method,
		output filter_method, output interlace_method, input ready);
	modport sink (input valid, input chunk_type_raw, input chunk_kind,
		input chunk_length, input crc_value, input image_width, input image_height,
		input bit_depth, input colour_type, input compression_method,
		input filter_method, input interlace_method, output ready);
endinterface

### hdl/png_chunk_deframer.sv
// PNG chunk deframer: splits a PNG byte stream into chunks and reports each one.
// Takes one file byte per cycle. The 8-byte signature is skipped unchecked; each
// chunk's length, type and CRC are gathered and, on the chunk's last CRC byte, one
// request carrying type, kind, length, CRC and the latched IHDR fields is placed in
// the result register. A length with bit 31 set counts as no data bytes. Every byte
// is consumed by the phase/counter logic; the input stalls only when a chunk's
// last CRC byte arrives while the previous request still sits in the result register.
`timescale 1ns / 1ps

module png_chunk_deframer
	import pcd_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	pcd_byte_if.sink      bytes,
	pcd_chunk_if.source   chunks
);

	typedef enum logic [2:0] {
		PH_SIG,
		PH_LEN,
		PH_TYPE,
		PH_DATA,
		PH_CRC
	} phase_t;

	phase_t             phase_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [31:0]        length_q;
	logic [31:0]        type_q;
	logic [31:0]        crc_q;
	logic [31:0]        width_q;
	logic [31:0]        height_q;
	logic [7:0]         hdr_q [5];

	logic               out_valid_q;
	logic [31:0]        out_type_q;
	chunk_kind_t        out_kind_q;
	logic [31:0]        out_length_q;
	logic [31:0]        out_crc_q;
	logic [31:0]        out_width_q;
	logic [31:0]        out_height_q;
	logic [7:0]         out_hdr_q [5];

	logic               emit_now;
	logic               take;
	logic [CNT_W-1:0]   cnt_inc;
	logic [31:0]        crc_new;

	assign emit_now     = (phase_q == PH_CRC) && (cnt_q[1:0] == 2'd3);
	assign bytes.ready  = !emit_now || !out_valid_q || chunks.ready;
	assign take         = bytes.valid && bytes.ready;
	assign cnt_inc      = cnt_q + CNT_W'(1);
	assign crc_new      = put_be(crc_q, cnt_q[1:0], bytes.byte_in);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIG;
			cnt_q       <= '0;
			length_q    <= '0;
			type_q      <= '0;
			crc_q       <= '0;
			width_q     <= '0;
			height_q    <= '0;
			for (int i = 0; i < 5; i++) begin
				hdr_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
		end else begin
			if (chunks.valid && chunks.ready && !(take && emit_now)) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				unique case (phase_q)
					PH_SIG: begin
						if (cnt_q == CNT_W'(SIG_BYTES - 1)) begin
							phase_q <= PH_LEN;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
					PH_LEN: begin
						length_q <= put_be(length_q, cnt_q[1:0], bytes.byte_in);
						if (cnt_q[1:0] == 2'd3) begin
							phase_q <= PH_TYPE;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
					PH_TYPE: begin
						type_q <= put_be(type_q, cnt_q[1:0], bytes.byte_in);
						if (cnt_q[1:0] == 2'd3) begin
							cnt_q   <= '0;
							phase_q <= (!length_q[31] && (length_q[30:0] != '0)) ?
								PH_DATA : PH_CRC;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
					PH_DATA: begin
						if (type_q == TAG_IHDR) begin
							if (cnt_q < CNT_W'(4)) begin
								width_q <= put_be(width_q, cnt_q[1:0], bytes.byte_in);
							end else if (cnt_q < CNT_W'(8)) begin
								height_q <= put_be(height_q, cnt_q[1:0], bytes.byte_in);
							end else if (cnt_q < CNT_W'(13)) begin
								hdr_q[cnt_q[2:0]] <= bytes.byte_in;
							end
						end
						if (cnt_inc == length_q[30:0]) begin
							phase_q <= PH_CRC;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_inc;
						end
					end
					PH_CRC: begin
						crc_q <= crc_new;
						if (cnt_q[1:0] == 2'd3) begin
							phase_q      <= PH_LEN;
							cnt_q        <= '0;
							out_valid_q  <= 1'b1;
							out_type_q   <= type_q;
							out_kind_q   <= kind_of(type_q);
							out_length_q <= length_q;
							out_crc_q    <= crc_new;
							out_width_q  <= width_q;
							out_height_q <= height_q;
							for (int i = 0; i < 5; i++) begin
								out_hdr_q[i] <= hdr_q[i];
							end
						end else begin
							cnt_q <= cnt_inc;
						end
					end
					default: begin
						phase_q <= PH_LEN;
						cnt_q   <= '0;
					end
				endcase
			end
		end
	end

	assign chunks.valid              = out_valid_q;
	assign chunks.chunk_type_raw     = out_type_q;
	assign chunks.chunk_kind         = out_kind_q;
	assign chunks.chunk_length       = out_length_q;
	assign chunks.crc_value          = out_crc_q;
	assign chunks.image_width        = out_width_q;
	assign chunks.image_height       = out_height_q;
	assign chunks.bit_depth          = out_hdr_q[0];
	assign chunks.colour_type        = out_hdr_q[1];
	assign chunks.compression_method = out_hdr_q[2];
	assign chunks.filter_method      = out_hdr_q[3];
	assign chunks.interlace_method   = out_hdr_q[4];

endmodule
